// File: hdl/e2g_pkg.sv
// ----------------------------------------------------------------------------
// e2g_pkg
// Shared types, constants and tables for the ECEF to geodetic converter.
// ----------------------------------------------------------------------------
package e2g_pkg;

    localparam int ITERATIONS = 5;
    localparam int IT_W       = $clog2(ITERATIONS) + 1;
    localparam int STAGES     = 30;
    localparam int SQRT_STEPS = 32;

    localparam logic [63:0]        INVK_Q32  = 64'd2608131497;
    localparam logic signed [63:0] INVK_Q30  = 64'sd652032874;
    localparam logic signed [63:0] QUARTER   = 64'sd1073741824;
    localparam logic signed [63:0] HALF_TURN = 64'sd2147483648;
    localparam logic [63:0]        ONE_Q30   = 64'd1073741824;
    localparam logic [63:0]        ONE_Q40   = 64'd1099511627776;
    localparam logic signed [63:0] ALT_MAX   = 64'sd34359738367;
    localparam logic signed [63:0] ALT_MIN   = -64'sd34359738368;
    localparam logic signed [63:0] HALF_MM   = 64'sd32768;

    localparam logic [32:0] SEMI_MAJOR_RST = 33'd6378137000;
    localparam logic [33:0] ECC_SQ_RST     = 34'd7360548646;

    localparam logic [6:0] SH_Q30     = 7'd30;
    localparam logic [6:0] SH_Q40     = 7'd40;
    localparam logic [6:0] SH_HGT     = 7'd14;
    localparam logic [6:0] SH_GAIN    = 7'd32;
    localparam logic [6:0] DIV_FRAC_N = 7'd30;
    localparam logic [6:0] DIV_RAD_N  = 7'd80;

    localparam logic CFG_SEMI_MAJOR = 1'b0;
    localparam logic CFG_ECC_SQ     = 1'b1;

    typedef enum logic [2:0] {
        OP_VEC, OP_ROT, OP_MUL, OP_SQRT, OP_DIV
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [6:0]  cnt;
    } t_alu_req;

    typedef enum logic [2:0] {
        ALU_IDLE, ALU_CORDIC, ALU_MUL, ALU_MULF, ALU_SQRT, ALU_DIV
    } t_alu_st;

    typedef enum logic [4:0] {
        S_IDLE, S_LON, S_GEO, S_ALT, S_N0SC, S_N0, S_NUM, S_RCHK, S_RDIV,
        S_TMUL, S_LAT0, S_ITSC, S_ITE, S_ITT, S_ITV, S_FSC, S_FPC, S_FZS,
        S_FA, S_PH, S_DONE, S_RE_SC, S_RE_RHO, S_RE_T, S_RE_ZZ, S_RE_V,
        S_RT_S2, S_RT_E, S_RT_SQ, S_PR
    } t_state;

    function automatic logic signed [63:0] arc_tab(input logic [4:0] i);
        logic signed [63:0] v;
        unique case (i)
            5'd0:  v = 64'sd536870912;
            5'd1:  v = 64'sd316933406;
            5'd2:  v = 64'sd167458907;
            5'd3:  v = 64'sd85004756;
            5'd4:  v = 64'sd42667331;
            5'd5:  v = 64'sd21354465;
            5'd6:  v = 64'sd10679838;
            5'd7:  v = 64'sd5340245;
            5'd8:  v = 64'sd2670163;
            5'd9:  v = 64'sd1335087;
            5'd10: v = 64'sd667544;
            5'd11: v = 64'sd333772;
            5'd12: v = 64'sd166886;
            5'd13: v = 64'sd83443;
            5'd14: v = 64'sd41722;
            5'd15: v = 64'sd20861;
            5'd16: v = 64'sd10430;
            5'd17: v = 64'sd5215;
            5'd18: v = 64'sd2608;
            5'd19: v = 64'sd1304;
            5'd20: v = 64'sd652;
            5'd21: v = 64'sd326;
            5'd22: v = 64'sd163;
            5'd23: v = 64'sd81;
            5'd24: v = 64'sd41;
            5'd25: v = 64'sd20;
            5'd26: v = 64'sd10;
            5'd27: v = 64'sd5;
            5'd28: v = 64'sd3;
            5'd29: v = 64'sd1;
            default: v = 64'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] clamp_lat(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > QUARTER) begin
            r = QUARTER;
        end else if (v < -QUARTER) begin
            r = -QUARTER;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

endpackage

// File: hdl/e2g_alu.sv
// ----------------------------------------------------------------------------
// e2g_alu
// Shared multi-cycle unit: CORDIC vectoring and rotation, rounded multiply,
// integer square root and restoring divide, one step per cycle.
// ----------------------------------------------------------------------------
module e2g_alu import e2g_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_alu_req    i_req,
    output logic        o_done,
    output logic [63:0] o_res0,
    output logic [63:0] o_res1
);

    t_alu_st r_st, n_st;
    t_alu_op r_op, n_op;
    logic signed [63:0] r_x, n_x, r_y, n_y, r_acc, n_acc;
    logic [6:0]   r_cnt, n_cnt, r_lim, n_lim;
    logic [127:0] r_prod, n_prod;
    logic [63:0]  r_ma, n_ma, r_mb, n_mb;
    logic         r_neg, n_neg;
    logic [5:0]   r_shift, n_shift;
    logic [63:0]  r_rem, n_rem, r_q, n_q, r_div, n_div;
    logic [79:0]  r_dvd, n_dvd;
    logic         r_done, n_done;
    logic [63:0]  r_res0, n_res0, r_res1, n_res1;

    logic signed [63:0] sh_x, sh_y, tab, cx, cy;
    logic [63:0]  pp, bit_v, trial, m;
    logic [127:0] rnd, sq;
    logic [64:0]  t_div;
    logic [1:0]   k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ALU_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_op <= n_op;  r_x <= n_x;  r_y <= n_y;  r_acc <= n_acc;
        r_cnt <= n_cnt;  r_lim <= n_lim;  r_prod <= n_prod;
        r_ma <= n_ma;  r_mb <= n_mb;  r_neg <= n_neg;  r_shift <= n_shift;
        r_rem <= n_rem;  r_q <= n_q;  r_div <= n_div;  r_dvd <= n_dvd;
        r_res0 <= n_res0;  r_res1 <= n_res1;
    end

    always_comb begin
        n_st = r_st;  n_op = r_op;  n_x = r_x;  n_y = r_y;  n_acc = r_acc;
        n_cnt = r_cnt;  n_lim = r_lim;  n_prod = r_prod;  n_ma = r_ma;
        n_mb = r_mb;  n_neg = r_neg;  n_shift = r_shift;  n_rem = r_rem;
        n_q = r_q;  n_div = r_div;  n_dvd = r_dvd;  n_done = 1'b0;
        n_res0 = r_res0;  n_res1 = r_res1;

        sh_x  = r_x >>> r_cnt[4:0];
        sh_y  = r_y >>> r_cnt[4:0];
        tab   = arc_tab(r_cnt[4:0]);
        k     = r_cnt[1:0];
        pp    = (k[1] ? r_ma[63:32] : r_ma[31:0]) * (k[0] ? r_mb[63:32] : r_mb[31:0]);
        rnd   = r_prod + (128'd1 << (r_shift - 6'd1));
        sq    = rnd >> r_shift;
        m     = (sq[127:64] != 64'd0) ? {64{1'b1}} : sq[63:0];
        if (m[63]) begin
            m = {1'b0, {63{1'b1}}};
        end
        bit_v = 64'd1 << (6'd62 - {r_cnt[4:0], 1'b0});
        trial = r_q + bit_v;
        t_div = {r_rem, r_dvd[79]};
        cx    = r_x;
        cy    = r_y;

        unique case (r_st)
            ALU_IDLE: begin
                if (i_start) begin
                    n_op  = i_req.op;
                    n_cnt = '0;
                    unique case (i_req.op)
                        OP_VEC: begin
                            n_x   = i_req.a;
                            n_y   = i_req.b;
                            n_acc = i_req.c;
                            if (i_req.a == 64'd0 && i_req.b == 64'd0) begin
                                n_res0 = i_req.c;
                                n_res1 = '0;
                                n_done = 1'b1;
                            end else begin
                                n_st = ALU_CORDIC;
                            end
                        end
                        OP_ROT: begin
                            n_x   = INVK_Q30;
                            n_y   = '0;
                            n_acc = i_req.a;
                            n_st  = ALU_CORDIC;
                        end
                        OP_MUL: begin
                            n_ma    = i_req.a[63] ? -i_req.a : i_req.a;
                            n_mb    = i_req.b[63] ? -i_req.b : i_req.b;
                            n_neg   = i_req.a[63] ^ i_req.b[63];
                            n_shift = i_req.cnt[5:0];
                            n_prod  = '0;
                            n_st    = ALU_MUL;
                        end
                        OP_SQRT: begin
                            n_rem = i_req.a;
                            n_q   = '0;
                            n_st  = ALU_SQRT;
                        end
                        OP_DIV: begin
                            n_rem = i_req.a;
                            n_div = i_req.b;
                            n_dvd = {i_req.c, 16'd0};
                            n_q   = '0;
                            n_lim = i_req.cnt;
                            n_st  = ALU_DIV;
                        end
                        default: n_st = ALU_IDLE;
                    endcase
                end
            end
            ALU_CORDIC: begin
                if (r_op == OP_VEC) begin
                    if (!r_y[63]) begin
                        cx = r_x + sh_y;  cy = r_y - sh_x;  n_acc = r_acc + tab;
                    end else begin
                        cx = r_x - sh_y;  cy = r_y + sh_x;  n_acc = r_acc - tab;
                    end
                end else begin
                    if (!r_acc[63]) begin
                        cx = r_x - sh_y;  cy = r_y + sh_x;  n_acc = r_acc - tab;
                    end else begin
                        cx = r_x + sh_y;  cy = r_y - sh_x;  n_acc = r_acc + tab;
                    end
                end
                n_x   = cx;
                n_y   = cy;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(STAGES - 1)) begin
                    if (r_op == OP_VEC) begin
                        n_ma    = cx[63] ? -cx : cx;
                        n_mb    = INVK_Q32;
                        n_neg   = cx[63];
                        n_shift = SH_GAIN[5:0];
                        n_prod  = '0;
                        n_cnt   = '0;
                        n_st    = ALU_MUL;
                    end else begin
                        n_res0 = cy;
                        n_res1 = cx;
                        n_done = 1'b1;
                        n_st   = ALU_IDLE;
                    end
                end
            end
            ALU_MUL: begin
                n_prod = r_prod + ({64'd0, pp} << {k[1] & k[0], k[1] ^ k[0], 5'd0});
                n_cnt  = r_cnt + 7'd1;
                if (k == 2'd3) begin
                    n_st = ALU_MULF;
                end
            end
            ALU_MULF: begin
                if (r_op == OP_VEC) begin
                    n_res0 = r_acc;
                    n_res1 = r_neg ? -m : m;
                end else begin
                    n_res0 = r_neg ? -m : m;
                end
                n_done = 1'b1;
                n_st   = ALU_IDLE;
            end
            ALU_SQRT: begin
                if (r_rem >= trial) begin
                    n_rem = r_rem - trial;
                    n_q   = (r_q >> 1) + bit_v;
                end else begin
                    n_q   = r_q >> 1;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(SQRT_STEPS - 1)) begin
                    n_res0 = n_q;
                    n_done = 1'b1;
                    n_st   = ALU_IDLE;
                end
            end
            ALU_DIV: begin
                if (t_div >= {1'b0, r_div}) begin
                    n_rem = 64'(t_div - {1'b0, r_div});
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = t_div[63:0];
                    n_q   = {r_q[62:0], 1'b0};
                end
                n_dvd = {r_dvd[78:0], 1'b0};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == r_lim - 7'd1) begin
                    n_res0 = n_q;
                    n_done = 1'b1;
                    n_st   = ALU_IDLE;
                end
            end
            default: n_st = ALU_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_res0 = r_res0;
    assign o_res1 = r_res1;

endmodule

// File: hdl/ecef_to_geodetic.sv
// ----------------------------------------------------------------------------
// ecef_to_geodetic
// Earth-centred X, Y, Z in millimetres to geodetic latitude, longitude and
// height above the configured ellipsoid.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until o_done pulses for one cycle with the result, which must be captured
// in that cycle since the receiver cannot stall. Every step runs through one
// shared unit, one step after another. An item takes less time on the polar axis
// than elsewhere, where the time is set mostly by the number of refinement
// passes (at most ITERATIONS). Configuration writes are taken at any time
// and must be made while busy is low.
module ecef_to_geodetic import e2g_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [35:0] i_pos_x,
    input  logic signed [35:0] i_pos_y,
    input  logic signed [35:0] i_pos_z,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [33:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [31:0] o_latitude,
    output logic [31:0]        o_longitude,
    output logic signed [35:0] o_altitude_mm,
    output logic               o_on_polar_axis
);

    t_state r_state, n_state, r_ret_re, n_ret_re, r_ret_rt, n_ret_rt;
    logic r_pend, n_pend, r_use_pr, n_use_pr, r_pole, n_pole, r_done, n_done;
    logic [32:0] r_semi;
    logic [33:0] r_ecc;
    logic signed [63:0] r_xq, n_xq, r_yq, n_yq, r_zq, n_zq, r_p, n_p, r_rp, n_rp;
    logic signed [63:0] r_s, n_s, r_c, n_c, r_re, n_re, r_alt, n_alt, r_den, n_den;
    logic signed [63:0] r_t, n_t, r_u, n_u, r_h, n_h;
    logic [63:0] r_d, n_d, r_n, n_n, r_num, n_num, r_ratio, n_ratio;
    logic signed [31:0] r_g, n_g, r_lat, n_lat, r_o_lat, n_o_lat;
    logic [31:0] r_lon, n_lon, r_o_lon, n_o_lon;
    logic signed [35:0] r_o_alt, n_o_alt;
    logic r_o_pole, n_o_pole;
    logic [IT_W-1:0] r_it, n_it;

    t_alu_req    alu_req;
    logic        alu_start, alu_need, alu_done;
    logic [63:0] alu_res0, alu_res1, dd;
    logic signed [63:0] hr, mm;
    logic signed [31:0] nl;

    e2g_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_req   (alu_req),
        .o_done  (alu_done),
        .o_res0  (alu_res0),
        .o_res1  (alu_res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_semi <= SEMI_MAJOR_RST;
            r_ecc  <= ECC_SQ_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEMI_MAJOR: r_semi <= i_cfg_data[32:0];
                CFG_ECC_SQ:     r_ecc  <= i_cfg_data;
                default:        r_ecc  <= r_ecc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_ret_re <= n_ret_re;  r_ret_rt <= n_ret_rt;  r_use_pr <= n_use_pr;
        r_pole <= n_pole;  r_xq <= n_xq;  r_yq <= n_yq;  r_zq <= n_zq;
        r_p <= n_p;  r_rp <= n_rp;  r_s <= n_s;  r_c <= n_c;  r_re <= n_re;
        r_alt <= n_alt;  r_den <= n_den;  r_t <= n_t;  r_u <= n_u;  r_h <= n_h;
        r_d <= n_d;  r_n <= n_n;  r_num <= n_num;  r_ratio <= n_ratio;
        r_g <= n_g;  r_lat <= n_lat;  r_lon <= n_lon;  r_it <= n_it;
        r_o_lat <= n_o_lat;  r_o_lon <= n_o_lon;  r_o_alt <= n_o_alt;
        r_o_pole <= n_o_pole;
    end

    always_comb begin
        n_state = r_state;  n_ret_re = r_ret_re;  n_ret_rt = r_ret_rt;
        n_pend = r_pend;  n_use_pr = r_use_pr;  n_pole = r_pole;  n_done = 1'b0;
        n_xq = r_xq;  n_yq = r_yq;  n_zq = r_zq;  n_p = r_p;  n_rp = r_rp;
        n_s = r_s;  n_c = r_c;  n_re = r_re;  n_alt = r_alt;  n_den = r_den;
        n_t = r_t;  n_u = r_u;  n_h = r_h;  n_d = r_d;  n_n = r_n;
        n_num = r_num;  n_ratio = r_ratio;  n_g = r_g;  n_lat = r_lat;
        n_lon = r_lon;  n_it = r_it;  n_o_lat = r_o_lat;  n_o_lon = r_o_lon;
        n_o_alt = r_o_alt;  n_o_pole = r_o_pole;

        alu_need    = 1'b0;
        alu_req.op  = OP_MUL;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.c   = '0;
        alu_req.cnt = SH_Q30;

        dd = (r_d >= ONE_Q30) ? 64'd1 : ONE_Q30 - r_d;
        nl = clamp_lat(alu_res0);
        hr = r_h + HALF_MM;
        mm = hr >>> 16;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_xq = {{12{i_pos_x[35]}}, i_pos_x, 16'd0};
                    n_yq = {{12{i_pos_y[35]}}, i_pos_y, 16'd0};
                    n_zq = {{12{i_pos_z[35]}}, i_pos_z, 16'd0};
                    n_lon = '0;
                    if (i_pos_x == 36'sd0 && i_pos_y == 36'sd0) begin
                        n_g      = i_pos_z[35] ? -QUARTER[31:0] : QUARTER[31:0];
                        n_lat    = i_pos_z[35] ? -QUARTER[31:0] : QUARTER[31:0];
                        n_pole   = 1'b1;
                        n_ret_re = S_PH;
                        n_state  = S_RE_SC;
                    end else begin
                        n_pole  = 1'b0;
                        n_state = S_LON;
                    end
                end
            end
            S_LON: begin
                alu_need   = 1'b1;
                alu_req.op = OP_VEC;
                alu_req.a  = r_xq[63] ? -r_xq : r_xq;
                alu_req.b  = r_xq[63] ? -r_yq : r_yq;
                alu_req.c  = r_xq[63] ? HALF_TURN : 64'd0;
                if (alu_done) begin
                    n_lon   = alu_res0[31:0];
                    n_p     = alu_res1;
                    n_state = S_GEO;
                end
            end
            S_GEO: begin
                alu_need   = 1'b1;
                alu_req.op = OP_VEC;
                alu_req.a  = r_p;
                alu_req.b  = r_zq;
                if (alu_done) begin
                    n_g      = nl;
                    n_rp     = alu_res1;
                    n_ret_re = S_ALT;
                    n_state  = S_RE_SC;
                end
            end
            S_ALT: begin
                n_alt   = r_rp - r_re;
                n_state = S_N0SC;
            end
            S_N0SC: begin
                alu_need   = 1'b1;
                alu_req.op = OP_ROT;
                alu_req.a  = {{32{r_g[31]}}, r_g};
                if (alu_done) begin
                    n_s      = alu_res0;
                    n_c      = alu_res1;
                    n_use_pr = 1'b1;
                    n_ret_rt = S_N0;
                    n_state  = S_RT_S2;
                end
            end
            S_N0: begin
                n_den   = r_n + r_alt;
                n_state = S_NUM;
            end
            S_NUM: begin
                alu_need    = 1'b1;
                alu_req.a   = {30'd0, r_ecc};
                alu_req.b   = r_n;
                alu_req.cnt = SH_Q40;
                if (alu_done) begin
                    n_num   = alu_res0;
                    n_state = S_RCHK;
                end
            end
            S_RCHK: begin
                if (r_den[63] || r_den == 64'sd0 || r_num >= r_den) begin
                    n_ratio = 64'd1;
                    n_state = S_TMUL;
                end else begin
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                alu_need    = 1'b1;
                alu_req.op  = OP_DIV;
                alu_req.a   = r_num;
                alu_req.b   = r_den;
                alu_req.cnt = DIV_FRAC_N;
                if (alu_done) begin
                    n_ratio = ONE_Q30 - alu_res0;
                    n_state = S_TMUL;
                end
            end
            S_TMUL: begin
                alu_need   = 1'b1;
                alu_req.a  = r_p;
                alu_req.b  = r_ratio;
                if (alu_done) begin
                    n_t     = alu_res0;
                    n_state = S_LAT0;
                end
            end
            S_LAT0: begin
                alu_need   = 1'b1;
                alu_req.op = OP_VEC;
                alu_req.a  = r_t;
                alu_req.b  = r_zq;
                if (alu_done) begin
                    n_lat   = nl;
                    n_it    = '0;
                    n_state = S_ITSC;
                end
            end
            S_ITSC: begin
                alu_need   = 1'b1;
                alu_req.op = OP_ROT;
                alu_req.a  = {{32{r_lat[31]}}, r_lat};
                if (alu_done) begin
                    n_s      = alu_res0;
                    n_c      = alu_res1;
                    n_use_pr = 1'b1;
                    n_ret_rt = S_ITE;
                    n_state  = S_RT_S2;
                end
            end
            S_ITE: begin
                alu_need    = 1'b1;
                alu_req.a   = r_n;
                alu_req.b   = {30'd0, r_ecc};
                alu_req.cnt = SH_Q40;
                if (alu_done) begin
                    n_u     = alu_res0;
                    n_state = S_ITT;
                end
            end
            S_ITT: begin
                alu_need   = 1'b1;
                alu_req.a  = r_u;
                alu_req.b  = r_s;
                if (alu_done) begin
                    n_t     = alu_res0;
                    n_state = S_ITV;
                end
            end
            S_ITV: begin
                alu_need   = 1'b1;
                alu_req.op = OP_VEC;
                alu_req.a  = r_p;
                alu_req.b  = r_zq + r_t;
                if (alu_done) begin
                    n_lat = nl;
                    n_it  = r_it + 1'b1;
                    if (nl == r_lat || r_it == IT_W'(ITERATIONS - 1)) begin
                        n_state = S_FSC;
                    end else begin
                        n_state = S_ITSC;
                    end
                end
            end
            S_FSC: begin
                alu_need   = 1'b1;
                alu_req.op = OP_ROT;
                alu_req.a  = {{32{r_lat[31]}}, r_lat};
                if (alu_done) begin
                    n_s     = alu_res0;
                    n_c     = alu_res1;
                    n_state = S_FPC;
                end
            end
            S_FPC: begin
                alu_need   = 1'b1;
                alu_req.a  = r_p;
                alu_req.b  = r_c;
                if (alu_done) begin
                    n_h     = alu_res0;
                    n_state = S_FZS;
                end
            end
            S_FZS: begin
                alu_need   = 1'b1;
                alu_req.a  = r_zq;
                alu_req.b  = r_s;
                if (alu_done) begin
                    n_h      = r_h + alu_res0;
                    n_use_pr = 1'b0;
                    n_ret_rt = S_FA;
                    n_state  = S_RT_S2;
                end
            end
            S_FA: begin
                alu_need    = 1'b1;
                alu_req.a   = {31'd0, r_semi};
                alu_req.b   = r_d;
                alu_req.cnt = SH_HGT;
                if (alu_done) begin
                    n_h     = r_h - alu_res0;
                    n_state = S_DONE;
                end
            end
            S_PH: begin
                n_h     = (r_zq[63] ? -r_zq : r_zq) - r_re;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (mm > ALT_MAX) begin
                    n_o_alt = ALT_MAX[35:0];
                end else if (mm < ALT_MIN) begin
                    n_o_alt = ALT_MIN[35:0];
                end else begin
                    n_o_alt = mm[35:0];
                end
                n_o_lat  = r_lat;
                n_o_lon  = r_lon;
                n_o_pole = r_pole;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_RE_SC: begin
                alu_need   = 1'b1;
                alu_req.op = OP_ROT;
                alu_req.a  = {{32{r_g[31]}}, r_g};
                if (alu_done) begin
                    n_s      = alu_res0;
                    n_c      = alu_res1;
                    n_use_pr = 1'b1;
                    n_ret_rt = S_RE_RHO;
                    n_state  = S_RT_S2;
                end
            end
            S_RE_RHO: begin
                alu_need   = 1'b1;
                alu_req.a  = r_n;
                alu_req.b  = r_c;
                if (alu_done) begin
                    n_t     = alu_res0;
                    n_state = S_RE_T;
                end
            end
            S_RE_T: begin
                alu_need    = 1'b1;
                alu_req.a   = r_n;
                alu_req.b   = ONE_Q40 - {30'd0, r_ecc};
                alu_req.cnt = SH_Q40;
                if (alu_done) begin
                    n_u     = alu_res0;
                    n_state = S_RE_ZZ;
                end
            end
            S_RE_ZZ: begin
                alu_need   = 1'b1;
                alu_req.a  = r_u;
                alu_req.b  = r_s;
                if (alu_done) begin
                    n_u     = alu_res0;
                    n_state = S_RE_V;
                end
            end
            S_RE_V: begin
                alu_need   = 1'b1;
                alu_req.op = OP_VEC;
                alu_req.a  = r_t;
                alu_req.b  = r_u;
                if (alu_done) begin
                    n_re    = alu_res1;
                    n_state = r_ret_re;
                end
            end
            S_RT_S2: begin
                alu_need   = 1'b1;
                alu_req.a  = r_s;
                alu_req.b  = r_s;
                if (alu_done) begin
                    n_d     = alu_res0;
                    n_state = S_RT_E;
                end
            end
            S_RT_E: begin
                alu_need    = 1'b1;
                alu_req.a   = {30'd0, r_ecc};
                alu_req.b   = r_d;
                alu_req.cnt = SH_Q40;
                if (alu_done) begin
                    n_d     = alu_res0;
                    n_state = S_RT_SQ;
                end
            end
            S_RT_SQ: begin
                alu_need   = 1'b1;
                alu_req.op = OP_SQRT;
                alu_req.a  = {dd[33:0], 30'd0};
                if (alu_done) begin
                    n_d     = (alu_res0 == 64'd0) ? 64'd1 : alu_res0;
                    n_state = r_use_pr ? S_PR : r_ret_rt;
                end
            end
            S_PR: begin
                alu_need    = 1'b1;
                alu_req.op  = OP_DIV;
                alu_req.a   = '0;
                alu_req.b   = r_d;
                alu_req.c   = {1'b0, r_semi, 30'd0};
                alu_req.cnt = DIV_RAD_N;
                if (alu_done) begin
                    n_n     = alu_res0;
                    n_state = r_ret_rt;
                end
            end
            default: n_state = S_IDLE;
        endcase

        alu_start = alu_need && !r_pend;
        if (alu_start) begin
            n_pend = 1'b1;
        end else if (alu_done) begin
            n_pend = 1'b0;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_latitude      = r_o_lat;
    assign o_longitude     = r_o_lon;
    assign o_altitude_mm   = r_o_alt;
    assign o_on_polar_axis = r_o_pole;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> busy)
        else $error("shared unit pending while idle");
    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_latitude <= 32'sd1073741824 && o_latitude >= -32'sd1073741824))
        else $error("latitude out of range");
    a_pole_lon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_on_polar_axis) |-> (o_longitude == 32'd0))
        else $error("pole result with nonzero longitude");
`endif

endmodule
